### sv/peak_segment_detector_unit_assert.svh
// Assertion macros for the peak segment detector.
// Used by the top level; the macros need clk and rst_n in the enclosing scope.
`ifndef PEAK_SEGMENT_DETECTOR_UNIT_ASSERT_SVH
`define PEAK_SEGMENT_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define PSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peak_segment_detector_unit: assertion failed");
// Implication in the next cycle.
`define PSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peak_segment_detector_unit: assertion failed");
`else
`define PSD_ASSERT_IMP(lbl, ante, cons)
`define PSD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/psd_pkg.sv
// Shared types and constants for the peak segment detector.
// No dependencies.
package psd_pkg;

  localparam int INDEX_BITS_DEF  = 20;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LEVEL_BITS      = 16;
  localparam int STRIDE_BITS     = 8;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_IDX_BITS    = 2;

  localparam logic [LEVEL_BITS-1:0]  ENTER_RESET  = 16'd28401; // 1.115 * 99.5 in Q8.8
  localparam logic [LEVEL_BITS-1:0]  EXIT_RESET   = 16'd28019; // 1.1 * 99.5 in Q8.8
  localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 8'd8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENTER  = 2'd0,
    CFG_EXIT   = 2'd1,
    CFG_STRIDE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_SEARCHING = 2'd0,
    MODE_IN_PEAK   = 2'd1,
    MODE_SKIPPING  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  enter_level;
    logic [LEVEL_BITS-1:0]  exit_level;
    logic [STRIDE_BITS-1:0] stride;
  } cfg_t;

endpackage

### sv/psd_cfg.sv
// Configuration register file for the peak segment detector.
// Depends on psd_pkg.
module psd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [psd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [psd_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
  output psd_pkg::cfg_t                      cfg
);

  psd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enter_level <= psd_pkg::ENTER_RESET;
      cfg_r.exit_level  <= psd_pkg::EXIT_RESET;
      cfg_r.stride      <= psd_pkg::STRIDE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        psd_pkg::CFG_ENTER:  cfg_r.enter_level <= cfg_wr_data[psd_pkg::LEVEL_BITS-1:0];
        psd_pkg::CFG_EXIT:   cfg_r.exit_level  <= cfg_wr_data[psd_pkg::LEVEL_BITS-1:0];
        psd_pkg::CFG_STRIDE: cfg_r.stride      <= cfg_wr_data[psd_pkg::STRIDE_BITS-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/psd_step.sv
// Combinational step of the detector: next state and result for one sample.
// Depends on psd_pkg.
module psd_step #(
  parameter int INDEX_BITS  = psd_pkg::INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = psd_pkg::SAMPLE_BITS_DEF
) (
  input  psd_pkg::cfg_t            cfg,
  input  psd_pkg::mode_t           mode,
  input  logic [INDEX_BITS-1:0]    idx,
  input  logic [INDEX_BITS-1:0]    anchor,
  input  logic [INDEX_BITS-1:0]    nck,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     last,
  output psd_pkg::mode_t           mode_nxt,
  output logic [INDEX_BITS-1:0]    idx_nxt,
  output logic [INDEX_BITS-1:0]    anchor_nxt,
  output logic [INDEX_BITS-1:0]    nck_nxt,
  output logic                     res_valid,
  output logic [INDEX_BITS-1:0]    res_begin,
  output logic [INDEX_BITS-1:0]    res_end,
  output logic                     res_truncated
);

  localparam int CMP_BITS = (SAMPLE_BITS > psd_pkg::LEVEL_BITS) ? SAMPLE_BITS
                                                                : psd_pkg::LEVEL_BITS;

  logic [psd_pkg::STRIDE_BITS-1:0] eff_stride;
  logic [INDEX_BITS-1:0]           idx_step;
  logic                            hit;
  logic                            above_enter;
  logic                            above_exit;
  logic                            open_pk;
  logic                            close_pk;
  logic                            keep_pk;
  psd_pkg::mode_t                  mode_eff;
  psd_pkg::mode_t                  mode_after;

  // stride zero behaves as one
  assign eff_stride  = (cfg.stride == '0) ? psd_pkg::STRIDE_BITS'(1) : cfg.stride;
  assign idx_step    = idx + INDEX_BITS'(eff_stride);
  assign hit         = (idx == nck);
  assign above_enter = CMP_BITS'(sample) > CMP_BITS'(cfg.enter_level);
  assign above_exit  = CMP_BITS'(sample) > CMP_BITS'(cfg.exit_level);

  // Skip ends on the resume index, so that sample is already searched.
  assign mode_eff = (mode == psd_pkg::MODE_SKIPPING && hit) ? psd_pkg::MODE_SEARCHING
                                                            : mode;

  // Next state
  always_comb begin
    open_pk    = 1'b0;
    close_pk   = 1'b0;
    keep_pk    = 1'b0;
    mode_after = mode_eff;
    unique case (mode_eff)
      psd_pkg::MODE_SEARCHING: begin
        if (above_enter) begin
          if (above_exit) begin
            open_pk    = 1'b1;
            mode_after = psd_pkg::MODE_IN_PEAK;
          end else begin
            close_pk   = 1'b1;   // opening sample fails its own exit check
            mode_after = psd_pkg::MODE_SKIPPING;
          end
        end
      end
      psd_pkg::MODE_IN_PEAK: begin
        if (hit) begin
          if (above_exit) begin
            keep_pk = 1'b1;
          end else begin
            close_pk   = 1'b1;
            mode_after = psd_pkg::MODE_SKIPPING;
          end
        end
      end
      psd_pkg::MODE_SKIPPING: ;
      default: mode_after = psd_pkg::MODE_SEARCHING;
    endcase
    mode_nxt = last ? psd_pkg::MODE_SEARCHING : mode_after;
  end

  // Counters and result
  always_comb begin
    res_valid     = close_pk || (last && mode_after == psd_pkg::MODE_IN_PEAK);
    res_begin     = anchor;
    res_end       = idx;
    res_truncated = !close_pk;

    if (last) begin
      idx_nxt    = '0;
      anchor_nxt = '0;
      nck_nxt    = '0;
    end else begin
      idx_nxt    = idx + INDEX_BITS'(1);
      anchor_nxt = anchor;
      if (close_pk || (mode_eff == psd_pkg::MODE_SEARCHING && !above_enter)) begin
        anchor_nxt = idx;
      end
      nck_nxt = (open_pk || close_pk || keep_pk) ? idx_step : nck;
    end
  end

endmodule

### sv/peak_segment_detector_unit.sv
// Top level of the hysteresis peak segment detector.
// Depends on psd_pkg, psd_cfg, psd_step and peak_segment_detector_unit_assert.svh.
//
// Usage:
//   in_*  : one unsigned Q8.8 sample per item, in_last marks the end of a stream.
//   out_* : one item per detected peak segment (begin index, end index,
//           truncated flag when the stream ended inside a peak).
//   cfg_* : register writes (enter level, exit level, stride), done while idle.
// Timing:
//   An accepted item lands in the input register; when it is processed, the
//   step logic updates the detector state and, if the item gives a result,
//   loads the result register, which drives out_valid. Throughput is one item
//   per cycle unless a result waits (see Stalls); the only loop is the state
//   update of the step logic.
// Stalls:
//   While out_valid is high and out_ready low, the input register still moves
//   as long as its sample produces no result; a sample that would produce one
//   waits in the input register, and in_ready drops behind it.
// Reset:
//   rst_n (synchronous, active low) clears both pipeline registers, returns
//   the detector to searching at index zero and reloads the default levels.
`include "peak_segment_detector_unit_assert.svh"

module peak_segment_detector_unit #(
  parameter int INDEX_BITS  = psd_pkg::INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = psd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             in_sample,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [INDEX_BITS-1:0]              out_seg_begin,
  output logic [INDEX_BITS-1:0]              out_seg_end,
  output logic                               out_truncated,
  input  logic                               cfg_wr_en,
  input  logic [psd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [psd_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);

  psd_pkg::cfg_t cfg;

  // input register
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   s1_last_r;

  // detector state
  psd_pkg::mode_t         mode_r;
  psd_pkg::mode_t         mode_nxt;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [INDEX_BITS-1:0]  idx_nxt;
  logic [INDEX_BITS-1:0]  anchor_r;
  logic [INDEX_BITS-1:0]  anchor_nxt;
  logic [INDEX_BITS-1:0]  nck_r;
  logic [INDEX_BITS-1:0]  nck_nxt;

  // step result
  logic                   res_valid;
  logic [INDEX_BITS-1:0]  res_begin;
  logic [INDEX_BITS-1:0]  res_end;
  logic                   res_truncated;

  // result register
  logic                   out_valid_r;
  logic [INDEX_BITS-1:0]  out_begin_r;
  logic [INDEX_BITS-1:0]  out_end_r;
  logic                   out_trunc_r;

  logic out_free;   // result register can take a new item this cycle
  logic step_en;    // input register item is processed this cycle
  logic out_load;

  psd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  psd_step #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .cfg           (cfg),
    .mode          (mode_r),
    .idx           (idx_r),
    .anchor        (anchor_r),
    .nck           (nck_r),
    .sample        (s1_sample_r),
    .last          (s1_last_r),
    .mode_nxt      (mode_nxt),
    .idx_nxt       (idx_nxt),
    .anchor_nxt    (anchor_nxt),
    .nck_nxt       (nck_nxt),
    .res_valid     (res_valid),
    .res_begin     (res_begin),
    .res_end       (res_end),
    .res_truncated (res_truncated)
  );

  assign out_free = !out_valid_r || out_ready;
  // A sample with no result never needs the result register.
  assign step_en  = s1_valid_r && (out_free || !res_valid);
  assign out_load = step_en && res_valid;
  assign in_ready = !s1_valid_r || step_en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r <= in_sample;
      s1_last_r   <= in_last;
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= psd_pkg::MODE_SEARCHING;
      idx_r    <= '0;
      anchor_r <= '0;
      nck_r    <= '0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
      anchor_r <= anchor_nxt;
      nck_r    <= nck_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_begin_r <= res_begin;
      out_end_r   <= res_end;
      out_trunc_r <= res_truncated;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_seg_begin = out_begin_r;
  assign out_seg_end   = out_end_r;
  assign out_truncated = out_trunc_r;

  // a waiting result is never overwritten
  `PSD_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_ready, !out_load)
  // an empty result register never blocks the input side
  `PSD_ASSERT_IMP(a_ready_when_free, !out_valid_r, in_ready)
  // end of stream puts the detector back at index zero, searching
  `PSD_ASSERT_NXT(a_last_clears, step_en && s1_last_r,
                  mode_r == psd_pkg::MODE_SEARCHING && idx_r == '0 && nck_r == '0)

endmodule

### bench/testbench.sv
// Self-checking bench for peak_segment_detector_unit: directed and random sample streams.
// Predicts every peak segment in step with accepted items and checks the results in order.
// Depends on psd_pkg and the RTL of the detector.
module testbench;

  localparam int IDX_W     = psd_pkg::INDEX_BITS_DEF;
  localparam int SMP_W     = psd_pkg::SAMPLE_BITS_DEF;
  localparam int LVL_W     = psd_pkg::LEVEL_BITS;
  localparam int STR_W     = psd_pkg::STRIDE_BITS;
  localparam int SETTLE    = 4;    // spare edges once every predicted segment is out
  localparam int LONG_HOLD = 300;  // receiver hold-off used to fill the block up
  localparam int MAX_MSGS  = 60;

  typedef struct packed {
    logic [IDX_W-1:0] seg_begin;
    logic [IDX_W-1:0] seg_end;
    logic             truncated;
  } segment_t;

  // DUT connections; every input starts at a known value
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [SMP_W-1:0]                  in_sample = '0;
  logic                              in_last = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [IDX_W-1:0]                  out_seg_begin;
  logic [IDX_W-1:0]                  out_seg_end;
  logic                              out_truncated;
  logic                              cfg_wr_en = 1'b0;
  logic [psd_pkg::CFG_IDX_BITS-1:0]  cfg_index = psd_pkg::CFG_ENTER;
  logic [psd_pkg::CFG_DATA_BITS-1:0] cfg_wr_data = '0;

  // Bench-side copy of the registers
  logic [LVL_W-1:0] lvl_enter = psd_pkg::ENTER_RESET;
  logic [LVL_W-1:0] lvl_exit  = psd_pkg::EXIT_RESET;
  logic [STR_W-1:0] lvl_stride = psd_pkg::STRIDE_RESET;

  // Bench-side copy of the detector state
  psd_pkg::mode_t   det_mode   = psd_pkg::MODE_SEARCHING;
  logic [IDX_W-1:0] det_index  = '0;
  logic [IDX_W-1:0] det_anchor = '0;
  logic [IDX_W-1:0] det_next   = '0;

  segment_t pending_segs[$];   // segments predicted but not yet seen on out_*
  int       errors = 0;
  bit       idle_on = 1'b1;    // random gaps on both sides when set
  bit       hold_req = 1'b0;   // asks the receiver for one long hold-off

  always #2 clk = ~clk;

  peak_segment_detector_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_seg_begin (out_seg_begin),
    .out_seg_end   (out_seg_end),
    .out_truncated (out_truncated),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Detector prediction: one call per accepted item, pushes at most one segment.
  // ---------------------------------------------------------------------------
  function automatic void advance_detector(logic [SMP_W-1:0] s, logic is_last);
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] step;
    bit               closed;
    i      = det_index;
    closed = 1'b0;
    step   = (lvl_stride == '0) ? IDX_W'(1) : IDX_W'(lvl_stride);  // stride 0 acts as 1

    // skip window over: back to searching on the resume index
    if (det_mode == psd_pkg::MODE_SKIPPING && i == det_next)
      det_mode = psd_pkg::MODE_SEARCHING;

    if (det_mode == psd_pkg::MODE_SEARCHING) begin
      if (s > lvl_enter) begin
        if (s > lvl_exit) begin
          det_mode = psd_pkg::MODE_IN_PEAK;
          det_next = i + step;
        end else begin
          // opening sample already fails the exit check: zero-length peak
          closed = 1'b1;
        end
      end else begin
        det_anchor = i;
      end
    end else if (det_mode == psd_pkg::MODE_IN_PEAK && i == det_next) begin
      if (s > lvl_exit)
        det_next = i + step;
      else
        closed = 1'b1;
    end

    if (closed) begin
      pending_segs.push_back('{seg_begin: det_anchor, seg_end: i, truncated: 1'b0});
      det_anchor = i;
      det_next   = i + step;
      det_mode   = psd_pkg::MODE_SKIPPING;
    end

    if (is_last) begin
      // stream ends inside an open peak: closed here, flagged truncated
      if (det_mode == psd_pkg::MODE_IN_PEAK && !closed)
        pending_segs.push_back('{seg_begin: det_anchor, seg_end: i, truncated: 1'b1});
      det_mode   = psd_pkg::MODE_SEARCHING;
      det_index  = '0;
      det_anchor = '0;
      det_next   = '0;
    end else begin
      det_index = i + 1'b1;
    end
  endfunction

  // Input side: predict on every accepted item
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      advance_detector(in_sample, in_last);
  end

  // Output side: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    segment_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_segs.size() == 0) begin
        errors++;
        if (errors <= MAX_MSGS)
          $display("%0t: unexpected segment begin=%0d end=%0d truncated=%0b",
                   $time, out_seg_begin, out_seg_end, out_truncated);
      end else begin
        want = pending_segs.pop_front();
        if (out_seg_begin !== want.seg_begin) begin
          errors++;
          if (errors <= MAX_MSGS)
            $display("%0t: seg_begin expected %0d, got %0d",
                     $time, want.seg_begin, out_seg_begin);
        end
        if (out_seg_end !== want.seg_end) begin
          errors++;
          if (errors <= MAX_MSGS)
            $display("%0t: seg_end expected %0d, got %0d", $time, want.seg_end, out_seg_end);
        end
        if (out_truncated !== want.truncated) begin
          errors++;
          if (errors <= MAX_MSGS)
            $display("%0t: truncated expected %0b, got %0b",
                     $time, want.truncated, out_truncated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly no gap, often short gaps, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Receiver: random ready pattern, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering items meanwhile.
  initial begin : result_sink
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (idle_on ? $urandom_range(1, 8) : 1) @(posedge clk);
        n = pick_gap();
        if (n > 0 && !hold_req) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  // Offers one item; returns on the edge where it is taken, valid still high.
  task automatic send_sample(logic [SMP_W-1:0] s, logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drops valid and waits until every predicted segment has come out.
  // The first edge lets the input monitor see the final accepted item.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all three registers; only called with the block drained.
  task automatic configure(logic [LVL_W-1:0] enter_v, logic [LVL_W-1:0] exit_v,
                           logic [STR_W-1:0] stride_v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= psd_pkg::CFG_ENTER;
    cfg_wr_data <= enter_v;
    @(posedge clk);
    cfg_index   <= psd_pkg::CFG_EXIT;
    cfg_wr_data <= exit_v;
    @(posedge clk);
    // upper data bits are don't-care for the stride register
    cfg_index   <= psd_pkg::CFG_STRIDE;
    cfg_wr_data <= {8'($urandom), stride_v};
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    lvl_enter  = enter_v;
    lvl_exit   = exit_v;
    lvl_stride = stride_v;
  endtask

  // Sample generator aimed at the current levels.
  function automatic logic [SMP_W-1:0] pick_sample(bit high);
    int r;
    int lo;
    int hi;
    lo = (lvl_enter < lvl_exit) ? lvl_enter : lvl_exit;
    hi = (lvl_enter < lvl_exit) ? lvl_exit : lvl_enter;
    r  = $urandom_range(0, 99);
    if (r < 12)
      return SMP_W'($urandom);
    if (r < 20) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return '1;
        2:       return lvl_enter;
        3:       return lvl_enter + 1'b1;
        4:       return lvl_exit;
        default: return lvl_exit + 1'b1;
      endcase
    end
    if (r < 30 && hi > lo)
      return SMP_W'($urandom_range(lo + 1, hi));
    if (high)
      return (hi == 65535) ? '1 : SMP_W'($urandom_range(hi + 1, 65535));
    return SMP_W'($urandom_range(0, lo));
  endfunction

  // Streams of random length made of high and low runs, a few items of noise,
  // and now and then a stream cut short by an early last.
  task automatic run_streams(int n_items, int max_len);
    int  sent;
    int  len;
    int  k;
    bit  high;
    logic is_last;
    sent = 0;
    while (sent < n_items) begin
      len  = $urandom_range(1, max_len);
      high = $urandom_range(0, 1);
      for (k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(0, 99) < 18)
          high = !high;
        is_last = (k == len - 1) || (sent == n_items - 1) || ($urandom_range(0, 99) < 2);
        send_sample(pick_sample(high), is_last);
        sent++;
        if (is_last)
          k = len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Reset levels and stride; a peak that opens on the first sample after a low
  // one and is still open when the stream ends.
  task automatic test_reset_defaults();
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(16'h1234, 1'b1);
  endtask

  // Stride one: every sample checked, no skip, start taken from the last end;
  // the stream ends with a fresh peak open.
  task automatic test_stride_one();
    configure(16'h8000, 16'h7FFF, 8'd1);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
  endtask

  // Exit level above enter level: peaks end on their opening sample.
  // Stride zero behaves as one; last on a closing sample is not truncated.
  task automatic test_immediate_exit();
    configure(16'h1000, 16'hFFFF, 8'd0);
    send_sample('1, 1'b0);
    send_sample(16'h2000, 1'b0);
    send_sample('0, 1'b0);
    send_sample(16'h1001, 1'b1);
  endtask

  // Level extremes: nothing can pass a full-scale enter level; with zero
  // levels any nonzero sample opens; widest stride.
  task automatic test_level_extremes();
    configure('1, '0, 8'd1);
    send_sample('1, 1'b0);
    send_sample('1, 1'b1);
    configure('0, '0, 8'd255);
    send_sample('0, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample('0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------
  // Hysteresis with exit at or below enter, small strides, idle on and off.
  task automatic test_random_hysteresis();
    logic [LVL_W-1:0] e;
    repeat (4) begin
      e = LVL_W'($urandom_range(16'h2000, 16'hE000));
      configure(e, e - LVL_W'($urandom_range(0, 16'h1800)),
                STR_W'($urandom_range(1, 4)));
      idle_on = $urandom_range(0, 3) != 0;
      run_streams(50, 30);
    end
    idle_on = 1'b1;
  endtask

  // Back-pressure: the receiver holds off while items keep coming, so the
  // result register fills and in_ready drops; then the sender pauses until all
  // results are out before a second burst.
  task automatic test_backpressure();
    configure(16'h6000, 16'h5800, 8'd1);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    run_streams(70, 10);
    wait_idle();
    idle_on = 1'b1;
    run_streams(50, 10);
  endtask

  // Exit at or above enter: mostly zero-length peaks and skips.
  task automatic test_random_high_exit();
    logic [LVL_W-1:0] e;
    repeat (2) begin
      e = LVL_W'($urandom_range(0, 16'hC000));
      configure(e, e + LVL_W'($urandom_range(0, 16'h3000)),
                STR_W'($urandom_range(0, 16)));
      run_streams(50, 40);
    end
  endtask

  // Wider strides with longer streams, full-range levels.
  task automatic test_random_wide_stride();
    repeat (3) begin
      configure(LVL_W'($urandom), LVL_W'($urandom),
                STR_W'($urandom_range(2, 40)));
      run_streams(40, 120);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_stride_one();
    test_immediate_exit();
    test_level_extremes();
    test_random_hysteresis();
    test_backpressure();
    test_random_high_exit();
    test_random_wide_stride();

    wait_idle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/psd_pkg.sv
sv/psd_cfg.sv
sv/psd_step.sv
sv/peak_segment_detector_unit.sv
bench/testbench.sv
